[rtl/core/recording_index_bitmap_allocator_unit_defines.svh]
// Assertion macros for the recording index bitmap allocator.
// Taken in by the top level; needs clk and rst_n in the including scope.
`ifndef RECORDING_INDEX_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define RECORDING_INDEX_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RIBA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define RIBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define RIBA_ASSERT_IMPLY(label, ante, cons)
`define RIBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/riba_pkg.sv]
// Shared types and constants of the recording index bitmap allocator.
// No dependencies.
package riba_pkg;

    typedef struct packed {
        logic        mode;
        logic [63:0] name_stem;
        logic [23:0] name_ext;
    } riba_req_t;

    typedef struct packed {
        logic [15:0] file_count;
        logic [7:0]  next_number;
        logic        full_res;
        logic [4:0]  slot_byte;
        logic [7:0]  slot_mask;
    } riba_rsp_t;

    // Classified request, as handed from the front to the back.
    typedef struct packed {
        logic       clear;
        logic       wav;
        logic       mark;
        logic [7:0] pos;
    } riba_op_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } riba_qstat_t;

    localparam logic        MODE_CLEAR = 1'b0;
    localparam logic [23:0] EXT_WAV    = {8'h57, 8'h41, 8'h56};
    localparam logic [39:0] STEM_MICR0 = {8'h4D, 8'h49, 8'h43, 8'h52, 8'h30};
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_TWO     = 8'h32;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [4:0]  LAST_BYTE  = 5'd31;
    localparam logic [2:0]  LAST_BIT   = 3'd7;

endpackage

[rtl/core/riba_front.sv]
// Front end: accepts requests and classifies the file name into an op.
// Depends on riba_pkg.
module riba_front
    import riba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  riba_req_t   req,
    input  riba_qstat_t q_stat,
    output logic        push_valid,
    output riba_op_t    push_op
);

    logic       op_valid_reg;
    logic       op_valid_next;
    riba_op_t   op_reg;
    riba_op_t   op_next;
    logic       accept;
    logic [7:0] d5;
    logic [7:0] d6;
    logic [7:0] d7;
    logic       is_wav;
    logic       is_micr;
    logic       digits_ok;
    logic [8:0] value;
    logic       in_range;

    always_comb
    begin
        d5        = req.name_stem[23:16];
        d6        = req.name_stem[15:8];
        d7        = req.name_stem[7:0];
        is_wav    = (req.name_ext == EXT_WAV);
        is_micr   = (req.name_stem[63:24] == STEM_MICR0);
        digits_ok = (d5 >= CH_ZERO) && (d5 <= CH_TWO) &&
                    (d6 >= CH_ZERO) && (d6 <= CH_NINE) &&
                    (d7 >= CH_ZERO) && (d7 <= CH_NINE);
        value     = 9'(d5[1:0]) * 9'd100 + 9'(d6[3:0]) * 9'd10 + 9'(d7[3:0]);
        in_range  = (value != 9'd0) && (value <= 9'd255);

        op_next.clear = (req.mode == MODE_CLEAR);
        op_next.wav   = !op_next.clear && is_wav;
        op_next.mark  = op_next.wav && is_micr && digits_ok && in_range;
        op_next.pos   = 8'(value - 9'd1);
    end

    assign req_stall  = op_valid_reg && q_stat.full;
    assign accept     = req_valid && !req_stall;
    assign push_valid = op_valid_reg;
    assign push_op    = op_reg;

    always_comb
    begin
        if (accept)
            op_valid_next = 1'b1;
        else if (op_valid_reg && !q_stat.full)
            op_valid_next = 1'b0;
        else
            op_valid_next = op_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_valid_reg <= 1'b0;
        else
            op_valid_reg <= op_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op_next;
    end

endmodule

[rtl/core/riba_queue.sv]
// Two-entry op queue between front and back.
// Depends on riba_pkg.
module riba_queue
    import riba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  riba_op_t    push_op,
    input  logic        pop,
    output riba_qstat_t q_stat,
    output riba_op_t    head_op
);

    riba_op_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop_ok;

    assign q_stat.full     = (cnt_reg == 2'd2);
    assign q_stat.nonempty = (cnt_reg != 2'd0);
    assign push            = push_valid && !q_stat.full;
    assign pop_ok          = pop && q_stat.nonempty;
    assign head_op         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop_ok)
            cnt_next = cnt_reg + 2'd1;
        else if (pop_ok && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop_ok)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

endmodule

[rtl/core/riba_back.sv]
// Back end: applies ops to the occupancy map and count, then searches
// for the lowest free number and holds the response. Depends on riba_pkg.
module riba_back
    import riba_pkg::*;
#(
    parameter int MAP_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  riba_qstat_t q_stat,
    input  riba_op_t    head_op,
    output logic        pop,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output riba_rsp_t   rsp
);

    localparam int NGRP   = (MAP_BYTES + 7) / 8;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int BYTE_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_APPLY,
        ST_GROUP,
        ST_SELECT,
        ST_PICK
    } state_t;

    function automatic logic [2:0] first_zero8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!v[k])
                r = 3'(k);
        end
        return r;
    endfunction

    state_t            state_reg;
    logic [7:0]        map_reg [MAP_BYTES];
    logic [15:0]       count_reg;
    logic [NGRP-1:0]   grp_free_reg;
    logic [2:0]        grp_idx_reg [NGRP];
    logic              sel_found_reg;
    logic [4:0]        sel_byte_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    riba_rsp_t         rsp_reg;

    logic [NGRP*8-1:0] byte_full;
    logic [NGRP-1:0]   grp_free_next;
    logic [2:0]        grp_idx_next [NGRP];
    logic              sel_found_next;
    logic [GRP_W-1:0]  sel_grp;
    logic [4:0]        sel_byte_next;
    logic [7:0]        pick_byte;
    logic [2:0]        pick_bit;
    logic              pick_full;
    riba_rsp_t         rsp_next;
    logic              out_free;
    logic              wr_ok;
    logic [BYTE_W-1:0] wr_byte;

    // Bytes past the map's end look full to the search.
    for (genvar g = 0; g < NGRP * 8; g++)
    begin : g_full
        if (g < MAP_BYTES)
        begin : g_real
            assign byte_full[g] = &map_reg[g];
        end
        else
        begin : g_pad
            assign byte_full[g] = 1'b1;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free_next[g] = !(&byte_full[g*8 +: 8]);
            grp_idx_next[g]  = first_zero8(byte_full[g*8 +: 8]);
        end
    end

    always_comb
    begin
        sel_found_next = 1'b0;
        sel_grp        = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                sel_found_next = 1'b1;
                sel_grp        = GRP_W'(g);
            end
        end
        sel_byte_next = 5'({sel_grp, grp_idx_reg[sel_grp]});
    end

    always_comb
    begin
        pick_byte = map_reg[sel_byte_reg[BYTE_W-1:0]];
        pick_bit  = first_zero8(pick_byte);
        pick_full = !sel_found_reg ||
                    ((sel_byte_reg == LAST_BYTE) && (pick_bit == LAST_BIT));
        rsp_next.file_count = count_reg;
        if (pick_full)
        begin
            rsp_next.next_number = 8'd0;
            rsp_next.full_res    = 1'b1;
            rsp_next.slot_byte   = 5'd0;
            rsp_next.slot_mask   = 8'd0;
        end
        else
        begin
            rsp_next.next_number = {sel_byte_reg, pick_bit} + 8'd1;
            rsp_next.full_res    = 1'b0;
            rsp_next.slot_byte   = sel_byte_reg;
            rsp_next.slot_mask   = 8'd1 << pick_bit;
        end
    end

    // Held while stalled, dropped once taken, raised when a pick lands.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if ((state_reg == ST_PICK) && out_free)
            rsp_valid_next = 1'b1;
    end

    assign pop       = (state_reg == ST_APPLY) && q_stat.nonempty;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign wr_ok     = head_op.mark && (32'(head_op.pos[7:3]) < MAP_BYTES);
    assign wr_byte   = BYTE_W'(head_op.pos[7:3]);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_APPLY;
            count_reg     <= 16'd0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAP_BYTES; i++)
                map_reg[i] <= 8'd0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;

            unique case (state_reg)
                ST_APPLY:
                begin
                    if (q_stat.nonempty)
                    begin
                        if (head_op.clear)
                        begin
                            count_reg <= 16'd0;
                            for (int i = 0; i < MAP_BYTES; i++)
                                map_reg[i] <= 8'd0;
                        end
                        else if (head_op.wav)
                        begin
                            if (count_reg != COUNT_MAX)
                                count_reg <= count_reg + 16'd1;
                            if (wr_ok)
                                map_reg[wr_byte][head_op.pos[2:0]] <= 1'b1;
                        end
                        state_reg <= ST_GROUP;
                    end
                end
                ST_GROUP:
                begin
                    state_reg <= ST_SELECT;
                end
                ST_SELECT:
                begin
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (out_free)
                        state_reg <= ST_APPLY;
                end
                default:
                begin
                    state_reg <= ST_APPLY;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GROUP)
        begin
            grp_free_reg <= grp_free_next;
            for (int g = 0; g < NGRP; g++)
                grp_idx_reg[g] <= grp_idx_next[g];
        end
        if (state_reg == ST_SELECT)
        begin
            sel_found_reg <= sel_found_next;
            sel_byte_reg  <= sel_byte_next;
        end
        if ((state_reg == ST_PICK) && out_free)
            rsp_reg <= rsp_next;
    end

endmodule

[rtl/core/recording_index_bitmap_allocator_unit.sv]
// Top level of the recording index bitmap allocator.
// Depends on riba_pkg, riba_front, riba_queue, riba_back and the defines header.
//
//  Channel | Signals                  | Direction | Moves
//  --------+--------------------------+-----------+-------------------------------
//  request | req_valid, req_stall, req| into unit | clear or one 8.3 file name
//  result  | rsp_valid, rsp_stall, rsp| out of unit| count, free number, byte, mask
//
// Sequencing: each request passes in order through the back sequencer's steps (apply, group
// scan of 8-byte groups, byte select, bit pick); the sequencer sets the rate.
// The front register and a two-entry queue take up to three more requests
// while the back works or while a response waits in its output register.
// Reset clears the map, the count and all handshake state at once; there is
// no clearing pass. A stalled response holds the back in its pick step only.
`include "recording_index_bitmap_allocator_unit_defines.svh"
module recording_index_bitmap_allocator_unit
    import riba_pkg::*;
#(
    parameter int MAP_BYTES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  riba_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output riba_rsp_t rsp
);

    riba_qstat_t q_stat;
    logic        push_valid;
    riba_op_t    push_op;
    logic        q_pop;
    riba_op_t    q_head;

    // Front: decodes the extension, the MICR0 stem and the three digits.
    riba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_op    (push_op)
    );

    // Decouples classification from the map update and search.
    riba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .pop        (q_pop),
        .q_stat     (q_stat),
        .head_op    (q_head)
    );

    // Back: owns the map and count, finds the first zero bit.
    riba_back #(
        .MAP_BYTES (MAP_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_op   (q_head),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A full response carries no number, byte or mask.
    `RIBA_ASSERT_IMPLY(a_full_zero, rsp_valid && rsp.full_res, rsp.next_number == 8'd0 && rsp.slot_mask == 8'd0 && rsp.slot_byte == 5'd0)
    // A free slot always has a single mask bit and a nonzero number.
    `RIBA_ASSERT_IMPLY(a_free_onehot, rsp_valid && !rsp.full_res, $onehot(rsp.slot_mask) && rsp.next_number != 8'd0)
    // With room in the queue the front never holds off a request.
    `RIBA_ASSERT_IMPLY(a_room_no_stall, !q_stat.full, !req_stall)
    // The back takes one op per search, never two in a row.
    `RIBA_ASSERT_NEXT(a_single_pop, q_pop, !q_pop)

endmodule

[bench/tb_recording_index_bitmap_allocator_unit.sv]
// Self-checking bench for recording_index_bitmap_allocator_unit: directed table, random
// file-name traffic and map fills, scored against a local shadow or hand-written expectations.
// Needs riba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_recording_index_bitmap_allocator_unit;
    import riba_pkg::*;

    localparam int          MAP_SIZE       = 32;
    localparam logic        MODE_NAME      = 1'b1;
    localparam int          RANDOM_ITEMS   = 2000;
    localparam int          STUCK_LIMIT    = 2000;    // cycles without any handshake
    localparam logic [23:0] EXT_TXT        = "TXT";

    typedef struct {
        riba_req_t r;
        bit        typed;      // row carries a hand-written expectation
        riba_rsp_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    riba_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    riba_rsp_t rsp;

    // Shadow state of the allocator
    logic [7:0]  map_shadow [0:MAP_SIZE-1];
    logic [15:0] wav_shadow;

    riba_rsp_t queued_reports [$];
    int        errors = 0;
    int        sent_total = 0;
    bit        quiet = 1'b0;      // no gaps and no stalls during this stretch
    int        stall_left = 0;
    int        stuck = 0;

    always #1 clk = ~clk;

    recording_index_bitmap_allocator_unit #(.MAP_BYTES(MAP_SIZE)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Shadow model: apply one request, then find the lowest free number.
    // ------------------------------------------------------------------
    function automatic riba_rsp_t predict_report(input riba_req_t r);
        riba_rsp_t  res;
        logic [7:0] d5, d6, d7;
        int         value;
        int         pos;
        int         b;
        if (r.mode == MODE_CLEAR) begin
            for (int i = 0; i < MAP_SIZE; i++)
                map_shadow[i] = 8'h00;
            wav_shadow = '0;
        end
        else if (r.name_ext == EXT_WAV) begin
            if (wav_shadow != COUNT_MAX)
                wav_shadow = wav_shadow + 16'd1;
            d5 = r.name_stem[23:16];
            d6 = r.name_stem[15:8];
            d7 = r.name_stem[7:0];
            // only MICR0 + three digits, leading digit 0..2, value 1..255
            if (r.name_stem[63:24] == STEM_MICR0
                && d5 >= CH_ZERO && d5 <= CH_TWO
                && d6 >= CH_ZERO && d6 <= CH_NINE
                && d7 >= CH_ZERO && d7 <= CH_NINE) begin
                value = (d5 - CH_ZERO) * 100 + (d6 - CH_ZERO) * 10 + (d7 - CH_ZERO);
                if (value >= 1 && value <= 255 && ((value - 1) >> 3) < MAP_SIZE)
                    map_shadow[(value - 1) >> 3][(value - 1) & 7] = 1'b1;
            end
        end

        res = '0;
        res.file_count = wav_shadow;
        res.full_res   = 1'b1;
        // first byte that is not all ones decides; position 256 means full
        for (int i = 0; i < MAP_SIZE; i++) begin
            if (map_shadow[i] != 8'hFF) begin
                b = 0;
                while (map_shadow[i][b])
                    b++;
                pos = i * 8 + b + 1;
                if (pos < 256) begin
                    res.next_number = 8'(pos);
                    res.full_res    = 1'b0;
                    res.slot_byte   = 5'(i);
                    res.slot_mask   = 8'(1 << b);
                end
                break;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    function automatic riba_req_t file_req(input logic [63:0] stem, input logic [23:0] ext);
        riba_req_t r;
        r.mode      = MODE_NAME;
        r.name_stem = stem;
        r.name_ext  = ext;
        return r;
    endfunction

    // MICR0ddd.WAV for a three-digit value 0..299
    function automatic riba_req_t recording_name(input int v);
        return file_req({STEM_MICR0, 8'(CH_ZERO + v / 100), 8'(CH_ZERO + (v / 10) % 10),
                         8'(CH_ZERO + v % 10)}, EXT_WAV);
    endfunction

    function automatic int pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 255);
        else if (roll < 90)
            return 0;
        else
            return $urandom_range(256, 299);
    endfunction

    // Near miss: one of the eleven name characters replaced at random
    function automatic riba_req_t garble(input riba_req_t r);
        int k;
        k = $urandom_range(0, 10);
        if (k < 8)
            r.name_stem[63 - 8 * k -: 8] = 8'($urandom_range(0, 255));
        else
            r.name_ext[23 - 8 * (k - 8) -: 8] = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic riba_req_t random_noise();
        riba_req_t r;
        r.mode      = 1'($urandom_range(0, 1));
        r.name_stem = {$urandom, $urandom};
        r.name_ext  = 24'($urandom);
        return r;
    endfunction

    function automatic riba_req_t clear_req();
        riba_req_t r;
        r           = random_noise();
        r.mode      = MODE_CLEAR;
        return r;
    endfunction

    // Present one request, hold it through stalls, log the expected report at accept.
    // Valid stays high between back-to-back requests.
    task automatic send_request(input riba_req_t r, input bit typed, input riba_rsp_t want);
        int        g;
        riba_rsp_t model_out;
        g = gap_len();
        if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        model_out = predict_report(r);
        queued_reports.push_back(typed ? want : model_out);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic send(input riba_req_t r);
        send_request(r, 1'b0, '0);
    endtask

    // Clear, then take every number in shuffled order; a few may be left
    // out first so the last free slot wanders before the map goes full.
    task automatic run_fill();
        int order [255];
        int skip;
        int j;
        int t;
        for (int i = 0; i < 255; i++)
            order[i] = i + 1;
        for (int i = 254; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        skip = $urandom_range(0, 3);
        send(clear_req());
        for (int i = 0; i < 255 - skip; i++) begin
            if ($urandom_range(0, 15) == 0)
                send(garble(recording_name(order[i])));
            send(recording_name(order[i]));
        end
        for (int i = 255 - skip; i < 255; i++)
            send(recording_name(order[i]));
        // already full: repeats and out-of-range values change nothing but the count
        repeat ($urandom_range(1, 4))
            send(recording_name(pick_value()));
    endtask

    // Small numbers only, so the free slot climbs across the first few bytes
    task automatic run_low_climb();
        send(clear_req());
        repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 7) == 0)
                send(random_noise());
            else
                send(recording_name($urandom_range(1, 48)));
        end
    endtask

    task automatic run_mixed();
        int roll;
        if ($urandom_range(0, 1))
            send(clear_req());
        repeat ($urandom_range(10, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                send(recording_name(pick_value()));
            else if (roll < 80)
                send(garble(recording_name(pick_value())));
            else if (roll < 92)
                send(random_noise());
            else
                send(file_req({$urandom, $urandom}, EXT_WAV));   // counted, not marked
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, held for their whole length
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 30) begin
            stall_left <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1)
                                                      : $urandom_range(2, 24);
            rsp_stall  <= 1'b1;
        end
        else begin
            rsp_stall <= 1'b0;
        end
    end

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Score every accepted result against the oldest outstanding expectation
    always @(posedge clk) begin
        riba_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (queued_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, rsp);
            end
            else begin
                want = queued_reports.pop_front();
                if (rsp.file_count !== want.file_count)
                    report_field("file_count", want.file_count, rsp.file_count);
                if (rsp.next_number !== want.next_number)
                    report_field("next_number", want.next_number, rsp.next_number);
                if (rsp.full_res !== want.full_res)
                    report_field("full_res", want.full_res, rsp.full_res);
                if (rsp.slot_byte !== want.slot_byte)
                    report_field("slot_byte", want.slot_byte, rsp.slot_byte);
                if (rsp.slot_mask !== want.slot_mask)
                    report_field("slot_mask", want.slot_mask, rsp.slot_mask);
            end
        end
    end

    // Watchdog: any accepted request or result restarts the count
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck <= 0;
        end
        else if (stuck >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, queued_reports.size());
            $display("tb_recording_index_bitmap_allocator_unit: done, errors");
            $finish;
        end
        else begin
            stuck <= stuck + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_row_t directed_rows [$];
        stim_row_t row;
        int        kind;

        // typed rows: clear state, first mark, and the marks at both ends
        row = '{'{MODE_CLEAR, 64'd0, 24'd0}, 1'b1, '{16'd0, 8'd1, 1'b0, 5'd0, 8'h01}};
        directed_rows.push_back(row);
        row = '{file_req("MICR0001", EXT_WAV), 1'b1, '{16'd1, 8'd2, 1'b0, 5'd0, 8'h02}};
        directed_rows.push_back(row);
        row = '{file_req("MICR0255", EXT_WAV), 1'b1, '{16'd2, 8'd2, 1'b0, 5'd0, 8'h02}};
        directed_rows.push_back(row);
        // digit value zero and 256..299: counted only
        directed_rows.push_back('{file_req("MICR0000", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0256", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0299", EXT_WAV), 1'b0, '0});
        // leading digit above 2, and characters just outside '0'..'9'
        directed_rows.push_back('{file_req("MICR0300", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0/09", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR00:9", EXT_WAV), 1'b0, '0});
        // wrong extension or wrong stem prefix, then valid marks
        directed_rows.push_back('{file_req("MICR0002", "wav"), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0002", EXT_TXT), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR1002", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("micr0002", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0002", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0248", EXT_WAV), 1'b0, '0});
        directed_rows.push_back('{file_req("MICR0008", EXT_WAV), 1'b0, '0});
        // payload extremes with a name request
        directed_rows.push_back('{file_req('1, '1), 1'b0, '0});
        directed_rows.push_back('{file_req('0, '0), 1'b0, '0});
        // clear ignores its payload
        row = '{'{MODE_CLEAR, '1, '1}, 1'b1, '{16'd0, 8'd1, 1'b0, 5'd0, 8'h01}};
        directed_rows.push_back(row);
        row = '{file_req("MICR0128", EXT_WAV), 1'b1, '{16'd1, 8'd1, 1'b0, 5'd0, 8'h01}};
        directed_rows.push_back(row);
        directed_rows.push_back('{file_req("MICR0001", EXT_WAV), 1'b0, '0});

        for (int i = 0; i < MAP_SIZE; i++)
            map_shadow[i] = 8'h00;
        wav_shadow = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);

        // Random episodes; each one picks its own idling style
        while (sent_total < directed_rows.size() + RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 15);
            if (kind == 0)
                run_fill();
            else if (kind < 4)
                run_low_climb();
            else
                run_mixed();
        end

        quiet = 1'b0;
        repeat (8)
            send(random_noise());

        req_valid <= 1'b0;
        while (queued_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);    // catch any stray result

        if (errors == 0)
            $display("tb_recording_index_bitmap_allocator_unit: done, clean");
        else
            $display("tb_recording_index_bitmap_allocator_unit: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/riba_pkg.sv
rtl/core/riba_front.sv
rtl/core/riba_queue.sv
rtl/core/riba_back.sv
rtl/core/recording_index_bitmap_allocator_unit.sv
bench/tb_recording_index_bitmap_allocator_unit.sv
